/* rtl/lclf_pkg.sv */
// ----------------------------------------------------------------------------
// lclf_pkg: shared constants for the locally connected layer block
// Store depths, address widths, request operation codes, result status codes
// and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lclf_pkg;

    localparam int PIXEL_DEPTH  = 4096;
    localparam int WEIGHT_DEPTH = 65536;
    localparam int BIAS_DEPTH   = 4096;

    localparam int PIX_AW  = $clog2(PIXEL_DEPTH);
    localparam int WGT_AW  = $clog2(WEIGHT_DEPTH);
    localparam int BIAS_AW = $clog2(BIAS_DEPTH);

    // Request operations.
    localparam logic [1:0] OP_PIXEL  = 2'd0;
    localparam logic [1:0] OP_WEIGHT = 2'd1;
    localparam logic [1:0] OP_BIAS   = 2'd2;
    localparam logic [1:0] OP_RUN    = 2'd3;

    // Result status.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INDEX = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CHANNELS = 3'd0;
    localparam logic [2:0] CFG_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_WIDTH    = 3'd2;
    localparam logic [2:0] CFG_KERNEL   = 3'd3;
    localparam logic [2:0] CFG_STRIDE   = 3'd4;
    localparam logic [2:0] CFG_PAD      = 3'd5;
    localparam logic [2:0] CFG_DILATION = 3'd6;
    localparam logic [2:0] CFG_OUTPUTS  = 3'd7;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

/* rtl/locally_connected_layer_forward.sv */
// ----------------------------------------------------------------------------
// locally_connected_layer_forward: one output of a locally connected layer
// Holds pixel, weight and bias stores loaded by write requests. A run request
// walks the im2col patch of one output position with one shared
// multiply-accumulate unit and returns a saturated Q16.16 value.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  cfg       cfg_write              cfg_index, cfg_data
//  in        in_valid / in_ready    operation, store_index, value,
//                                   out_channel, out_row, out_col
//  out       out_valid / out_ready  out_value, status
//
// A store write is performed in the idle state. A run request sizes the
// output map (two 8-step divisions by the stride), passes the set-up states
// S_SET0 to S_SET4, walks one kernel tap per cycle (channels * kernel_size^2
// taps) and drains the multiply-accumulate pipeline before its result goes.
// After reset all 4096 bias entries are cleared, one entry a cycle, during
// which in_ready stays low. A pending result stalls only the next
// request; a request may be taken in the cycle its predecessor's result goes.

`default_nettype none

module locally_connected_layer_forward
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [6:0]         cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         operation,
    input  wire logic [15:0]        store_index,
    input  wire logic signed [31:0] value,
    input  wire logic [3:0]         out_channel,
    input  wire logic [5:0]         out_row,
    input  wire logic [5:0]         out_col,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      out_value,
    output logic [1:0]              status
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DIVH   = 4'd2;
    localparam logic [3:0] S_DIVW   = 4'd3;
    localparam logic [3:0] S_SET0   = 4'd4;
    localparam logic [3:0] S_SET1   = 4'd5;
    localparam logic [3:0] S_SET2   = 4'd6;
    localparam logic [3:0] S_SET3   = 4'd7;
    localparam logic [3:0] S_SET4   = 4'd8;
    localparam logic [3:0] S_WALK   = 4'd9;
    localparam logic [3:0] S_FINISH = 4'd10;

    // Configuration.
    logic [4:0] chan_reg;
    logic [6:0] h_reg;
    logic [6:0] w_reg;
    logic [2:0] ks_reg;
    logic [2:0] st_reg;
    logic [1:0] pad_reg;
    logic [2:0] dil_reg;
    logic [4:0] nout_reg;

    // Control.
    logic [3:0]                      state_reg, state_next;
    logic [lclf_pkg::BIAS_AW-1:0]    clr_reg, clr_next;
    logic                            err_reg, err_next;
    logic                            s1_reg, s1_next;
    logic                            s2_reg, s2_next;
    logic                            out_valid_reg, out_valid_next;
    logic [2:0]                      cnt_reg, cnt_next;

    // Datapath.
    logic [7:0]                      q_reg, q_next;
    logic [2:0]                      r_reg, r_next;
    logic [3:0]                      m_reg, m_next;
    logic [5:0]                      oy_reg, oy_next;
    logic [5:0]                      ox_reg, ox_next;
    logic [8:0]                      hout_reg, hout_next;
    logic [8:0]                      wout_reg, wout_next;
    logic [15:0]                     n_reg, n_next;
    logic [7:0]                      kc_reg, kc_next;
    logic [15:0]                     nn_reg, nn_next;
    logic [10:0]                     kk_reg, kk_next;
    logic [19:0]                     bidx_reg, bidx_next;
    logic [14:0]                     mk_reg, mk_next;
    logic [31:0]                     widx_reg, widx_next;
    logic signed [10:0]              iy0_reg, iy0_next;
    logic signed [10:0]              ix0_reg, ix0_next;
    logic signed [10:0]              iy_reg, iy_next;
    logic signed [10:0]              ix_reg, ix_next;
    logic [9:0]                      dilw_reg, dilw_next;
    logic [13:0]                     hw_reg, hw_next;
    logic signed [17:0]              row0_reg, row0_next;
    logic signed [17:0]              row_reg, row_next;
    logic [18:0]                     chb_reg, chb_next;
    logic [4:0]                      c_reg, c_next;
    logic [2:0]                      ky_reg, ky_next;
    logic [2:0]                      kx_reg, kx_next;
    logic signed [31:0]              prod_reg, prod_next;
    logic signed [47:0]              acc_reg, acc_next;
    logic signed [31:0]              out_value_reg, out_value_next;
    logic [1:0]                      status_reg, status_next;

    // Stores and their registered read data.
    logic [15:0] pixel_mem  [lclf_pkg::PIXEL_DEPTH];
    logic [15:0] weight_mem [lclf_pkg::WEIGHT_DEPTH];
    logic [31:0] bias_mem   [lclf_pkg::BIAS_DEPTH];
    logic signed [15:0] w_rd_reg;
    logic signed [15:0] p_rd_reg;
    logic [31:0]        bias_rd_reg;

    logic                          pix_we, wgt_we, bias_we;
    logic [lclf_pkg::BIAS_AW-1:0]  bias_wa;
    logic [31:0]                   bias_wd;

    // Derived geometry.
    logic [2:0]         ks_eff, st_eff, ksm1;
    logic [5:0]         ext;
    logic [7:0]         sum_h, sum_w, span_h, span_w;
    logic               neg_h, neg_w;
    logic [3:0]         div_t;
    logic               div_ge;
    logic [7:0]         q_step;
    logic               accept;
    logic               slot_free;
    logic               inb;
    logic signed [20:0] pidx;
    logic               pix_oob, wgt_oob;
    logic               last_tap;

    assign ks_eff = (ks_reg == 3'd0) ? 3'd1 : ks_reg;
    assign st_eff = (st_reg == 3'd0) ? 3'd1 : st_reg;
    assign ksm1   = ks_eff - 3'd1;
    assign ext    = 6'({3'b0, dil_reg} * {3'b0, ksm1}) + 6'd1;
    assign sum_h  = {1'b0, h_reg} + {5'b0, pad_reg, 1'b0};
    assign sum_w  = {1'b0, w_reg} + {5'b0, pad_reg, 1'b0};
    assign neg_h  = sum_h < {2'b0, ext};
    assign neg_w  = sum_w < {2'b0, ext};
    assign span_h = sum_h - {2'b0, ext};
    assign span_w = sum_w - {2'b0, ext};

    // One restoring division step by the stride.
    assign div_t  = {r_reg, q_reg[7]};
    assign div_ge = div_t >= {1'b0, st_eff};
    assign q_step = {q_reg[6:0], div_ge};

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;

    assign inb = !iy_reg[10] && ($unsigned(iy_reg) < {4'b0, h_reg}) &&
                 !ix_reg[10] && ($unsigned(ix_reg) < {4'b0, w_reg});
    assign pidx = $signed({2'b0, chb_reg}) + $signed({{3{row_reg[17]}}, row_reg}) +
                  $signed({{10{ix_reg[10]}}, ix_reg});
    assign pix_oob = inb && ($unsigned(pidx) >= 21'(lclf_pkg::PIXEL_DEPTH));
    assign wgt_oob = widx_reg >= 32'(lclf_pkg::WEIGHT_DEPTH);
    assign last_tap = (kx_reg == ksm1) && (ky_reg == ksm1) &&
                      (c_reg == (chan_reg - 5'd1));

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        err_next       = err_reg;
        s1_next        = 1'b0;
        s2_next        = s1_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        cnt_next       = cnt_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        m_next         = m_reg;
        oy_next        = oy_reg;
        ox_next        = ox_reg;
        hout_next      = hout_reg;
        wout_next      = wout_reg;
        n_next         = n_reg;
        kc_next        = kc_reg;
        nn_next        = nn_reg;
        kk_next        = kk_reg;
        bidx_next      = bidx_reg;
        mk_next        = mk_reg;
        widx_next      = widx_reg;
        iy0_next       = iy0_reg;
        ix0_next       = ix0_reg;
        iy_next        = iy_reg;
        ix_next        = ix_reg;
        dilw_next      = dilw_reg;
        hw_next        = hw_reg;
        row0_next      = row0_reg;
        row_next       = row_reg;
        chb_next       = chb_reg;
        c_next         = c_reg;
        ky_next        = ky_reg;
        kx_next        = kx_reg;
        prod_next      = w_rd_reg * p_rd_reg;
        acc_next       = s2_reg ? acc_reg + 48'(prod_reg) : acc_reg;
        pix_we         = 1'b0;
        wgt_we         = 1'b0;
        bias_we        = 1'b0;
        bias_wa        = store_index[lclf_pkg::BIAS_AW-1:0];
        bias_wd        = value;

        case (state_reg)
            S_CLEAR:
            begin
                bias_we  = 1'b1;
                bias_wa  = clr_reg;
                bias_wd  = '0;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        lclf_pkg::OP_PIXEL:
                        begin
                            if ({1'b0, store_index} < 17'(lclf_pkg::PIXEL_DEPTH))
                            begin
                                pix_we = 1'b1;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                out_value_next = '0;
                                status_next    = lclf_pkg::ST_INDEX;
                            end
                        end
                        lclf_pkg::OP_WEIGHT:
                        begin
                            if ({1'b0, store_index} < 17'(lclf_pkg::WEIGHT_DEPTH))
                            begin
                                wgt_we = 1'b1;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                out_value_next = '0;
                                status_next    = lclf_pkg::ST_INDEX;
                            end
                        end
                        lclf_pkg::OP_BIAS:
                        begin
                            if ({1'b0, store_index} < 17'(lclf_pkg::BIAS_DEPTH))
                            begin
                                bias_we = 1'b1;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                out_value_next = '0;
                                status_next    = lclf_pkg::ST_INDEX;
                            end
                        end
                        default:
                        begin
                            m_next     = out_channel;
                            oy_next    = out_row;
                            ox_next    = out_col;
                            err_next   = 1'b0;
                            q_next     = span_h;
                            r_next     = '0;
                            cnt_next   = '0;
                            state_next = S_DIVH;
                        end
                    endcase
                end
            end
            S_DIVH, S_DIVW:
            begin
                q_next   = q_step;
                r_next   = div_ge ? 3'(div_t - {1'b0, st_eff}) : div_t[2:0];
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    if (state_reg == S_DIVH)
                    begin
                        hout_next  = neg_h ? 9'd0 : {1'b0, q_step} + 9'd1;
                        q_next     = span_w;
                        r_next     = '0;
                        state_next = S_DIVW;
                    end
                    else
                    begin
                        wout_next  = neg_w ? 9'd0 : {1'b0, q_step} + 9'd1;
                        state_next = S_SET0;
                    end
                end
            end
            S_SET0:
            begin
                n_next  = 16'({10'b0, oy_reg} * {7'b0, wout_reg}) + {10'b0, ox_reg};
                kc_next = 8'({3'b0, chan_reg} * {5'b0, ks_eff});
                if (({1'b0, m_reg} >= nout_reg) || ({3'b0, oy_reg} >= hout_reg) ||
                    ({3'b0, ox_reg} >= wout_reg))
                begin
                    err_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SET1;
                end
            end
            S_SET1:
            begin
                nn_next    = 16'({7'b0, hout_reg} * {7'b0, wout_reg});
                kk_next    = 11'({3'b0, kc_reg} * {8'b0, ks_eff});
                state_next = S_SET2;
            end
            S_SET2:
            begin
                bidx_next = 20'({16'b0, m_reg} * {4'b0, nn_reg}) + {4'b0, n_reg};
                mk_next   = 15'({11'b0, m_reg} * {4'b0, kk_reg});
                if (bidx_next >= 20'(lclf_pkg::BIAS_DEPTH))
                begin
                    err_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SET3;
                end
            end
            S_SET3:
            begin
                // Bias read is in flight during this cycle.
                widx_next  = 32'({17'b0, mk_reg} * {16'b0, nn_reg}) + {16'b0, n_reg};
                iy0_next   = $signed(11'({5'b0, oy_reg} * {8'b0, st_eff})) -
                             $signed({9'b0, pad_reg});
                ix0_next   = $signed(11'({5'b0, ox_reg} * {8'b0, st_eff})) -
                             $signed({9'b0, pad_reg});
                dilw_next  = 10'({7'b0, dil_reg} * {3'b0, w_reg});
                hw_next    = 14'({7'b0, h_reg} * {7'b0, w_reg});
                state_next = S_SET4;
            end
            S_SET4:
            begin
                acc_next  = 48'($signed(bias_rd_reg));
                row0_next = $signed({{7{iy0_reg[10]}}, iy0_reg}) *
                            $signed({11'b0, w_reg});
                row_next  = row0_next;
                iy_next   = iy0_reg;
                ix_next   = ix0_reg;
                chb_next  = '0;
                c_next    = '0;
                ky_next   = '0;
                kx_next   = '0;
                state_next = (chan_reg == 5'd0) ? S_FINISH : S_WALK;
            end
            S_WALK:
            begin
                if (wgt_oob || pix_oob)
                begin
                    err_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    // Padding taps still read a weight but add nothing.
                    s1_next   = inb;
                    widx_next = widx_reg + {16'b0, nn_reg};
                    if (kx_reg != ksm1)
                    begin
                        kx_next = kx_reg + 3'd1;
                        ix_next = ix_reg + $signed({8'b0, dil_reg});
                    end
                    else
                    begin
                        kx_next = '0;
                        ix_next = ix0_reg;
                        if (ky_reg != ksm1)
                        begin
                            ky_next  = ky_reg + 3'd1;
                            iy_next  = iy_reg + $signed({8'b0, dil_reg});
                            row_next = row_reg + $signed({8'b0, dilw_reg});
                        end
                        else
                        begin
                            ky_next  = '0;
                            iy_next  = iy0_reg;
                            row_next = row0_reg;
                            c_next   = c_reg + 5'd1;
                            chb_next = chb_reg + {5'b0, hw_reg};
                        end
                    end
                    if (last_tap)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (!s1_reg && !s2_reg && slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (err_reg)
                    begin
                        out_value_next = '0;
                        status_next    = lclf_pkg::ST_INDEX;
                    end
                    else if (acc_reg > 48'(lclf_pkg::Q_MAX))
                    begin
                        out_value_next = lclf_pkg::Q_MAX;
                        status_next    = lclf_pkg::ST_SAT;
                    end
                    else if (acc_reg < 48'(lclf_pkg::Q_MIN))
                    begin
                        out_value_next = lclf_pkg::Q_MIN;
                        status_next    = lclf_pkg::ST_SAT;
                    end
                    else
                    begin
                        out_value_next = acc_reg[31:0];
                        status_next    = lclf_pkg::ST_OK;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            err_reg       <= 1'b0;
            s1_reg        <= 1'b0;
            s2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            chan_reg      <= 5'd1;
            h_reg         <= 7'd8;
            w_reg         <= 7'd8;
            ks_reg        <= 3'd3;
            st_reg        <= 3'd1;
            pad_reg       <= 2'd0;
            dil_reg       <= 3'd1;
            nout_reg      <= 5'd1;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            err_reg       <= err_next;
            s1_reg        <= s1_next;
            s2_reg        <= s2_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    lclf_pkg::CFG_CHANNELS: chan_reg <= cfg_data[4:0];
                    lclf_pkg::CFG_HEIGHT:   h_reg    <= cfg_data;
                    lclf_pkg::CFG_WIDTH:    w_reg    <= cfg_data;
                    lclf_pkg::CFG_KERNEL:   ks_reg   <= cfg_data[2:0];
                    lclf_pkg::CFG_STRIDE:   st_reg   <= cfg_data[2:0];
                    lclf_pkg::CFG_PAD:      pad_reg  <= cfg_data[1:0];
                    lclf_pkg::CFG_DILATION: dil_reg  <= cfg_data[2:0];
                    default:                nout_reg <= cfg_data[4:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        q_reg         <= q_next;
        r_reg         <= r_next;
        m_reg         <= m_next;
        oy_reg        <= oy_next;
        ox_reg        <= ox_next;
        hout_reg      <= hout_next;
        wout_reg      <= wout_next;
        n_reg         <= n_next;
        kc_reg        <= kc_next;
        nn_reg        <= nn_next;
        kk_reg        <= kk_next;
        bidx_reg      <= bidx_next;
        mk_reg        <= mk_next;
        widx_reg      <= widx_next;
        iy0_reg       <= iy0_next;
        ix0_reg       <= ix0_next;
        iy_reg        <= iy_next;
        ix_reg        <= ix_next;
        dilw_reg      <= dilw_next;
        hw_reg        <= hw_next;
        row0_reg      <= row0_next;
        row_reg       <= row_next;
        chb_reg       <= chb_next;
        c_reg         <= c_next;
        ky_reg        <= ky_next;
        kx_reg        <= kx_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            pixel_mem[store_index[lclf_pkg::PIX_AW-1:0]] <= value[15:0];
        end
        p_rd_reg <= pixel_mem[pidx[lclf_pkg::PIX_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wgt_we)
        begin
            weight_mem[store_index[lclf_pkg::WGT_AW-1:0]] <= value[15:0];
        end
        w_rd_reg <= weight_mem[widx_reg[lclf_pkg::WGT_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (bias_we)
        begin
            bias_mem[bias_wa] <= bias_wd;
        end
        bias_rd_reg <= bias_mem[bidx_reg[lclf_pkg::BIAS_AW-1:0]];
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign status    = status_reg;

    // A run request always starts with the output height division.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (operation == lclf_pkg::OP_RUN) |=> state_reg == S_DIVH)
        else $error("run request did not start the sizing division");

    // A saturated result holds one of the two clamp values.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == lclf_pkg::ST_SAT) |->
        (out_value == lclf_pkg::Q_MAX) || (out_value == lclf_pkg::Q_MIN))
        else $error("saturated result is not a clamp value");

    // An index fault always reports a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == lclf_pkg::ST_INDEX) |-> out_value == 32'sd0)
        else $error("index fault result carries a non-zero value");

endmodule

`default_nettype wire
